// ----- design/u8dec_pkg.sv -----
`default_nettype none

package u8dec_pkg;

    localparam int unsigned ByteWidth = 8;
    localparam int unsigned CodeWidth = 31;
    localparam int unsigned PendWidth = 3;
    localparam int unsigned LeadBitsWidth = 5;
    localparam int unsigned ContBits = 6;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_STRAY   = 3'd1,
        ST_BADLEAD = 3'd2,
        ST_BADCONT = 3'd3,
        ST_TRUNC   = 3'd4
    } status_t;

    // What a lead byte of a multi-byte sequence sets up
    typedef struct packed {
        logic                     valid;
        logic [PendWidth-1:0]     more;
        logic [LeadBitsWidth-1:0] bits;
    } lead_info_t;

    function automatic lead_info_t decode_lead(input logic [ByteWidth-1:0] b);
        lead_info_t info;
        info.valid = 1'b1;
        info.more  = '0;
        info.bits  = '0;
        if (b[5] == 1'b0) begin
            info.more = 3'd1;
            info.bits = b[4:0];
        end else if (b[4] == 1'b0) begin
            info.more = 3'd2;
            info.bits = {1'b0, b[3:0]};
        end else if (b[3] == 1'b0) begin
            info.more = 3'd3;
            info.bits = {2'b0, b[2:0]};
        end else if (b[2] == 1'b0) begin
            info.more = 3'd4;
            info.bits = {3'b0, b[1:0]};
        end else if (b[1] == 1'b0) begin
            info.more = 3'd5;
            info.bits = {4'b0, b[0]};
        end else begin
            info.valid = 1'b0;
        end
        return info;
    endfunction

endpackage

`default_nettype wire

// ----- design/utf8_byte_stream_decoder_unit.sv -----
// A result is registered and appears on the m_ side in the cycle after the byte that completes it.
// Throughput: one byte per cycle while s_ready is high; the decode state updates on each
// accepted byte, the result register only on bytes that emit a word, and a held result
// does not stop the next byte while m_ready is high.
// Reset: synchronous, active low; clears the decode state, the drop flag and m_valid.
`default_nettype none

module utf8_byte_stream_decoder_unit
    import u8dec_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [ByteWidth-1:0] s_data_byte,
    input  wire logic                 s_last_byte,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [CodeWidth-1:0]      m_code_point,
    output logic [2:0]                m_status,
    output logic                      m_text_end
);

    logic [PendWidth-1:0] pending_reg, pending_next;
    logic [CodeWidth-1:0] partial_reg, partial_next;
    logic                 halted_reg, halted_next;

    logic                 m_valid_reg;
    logic [CodeWidth-1:0] code_reg;
    status_t              status_reg;
    logic                 end_reg;

    logic                 accept;
    logic                 emit;
    logic [CodeWidth-1:0] emit_code;
    status_t              emit_status;
    lead_info_t           lead;
    logic [CodeWidth-1:0] shifted;
    logic [PendWidth-1:0] pending_dec;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign lead        = decode_lead(s_data_byte);
    assign shifted     = {partial_reg[CodeWidth-ContBits-1:0], s_data_byte[ContBits-1:0]};
    assign pending_dec = pending_reg - 3'd1;

    always_comb begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        halted_next  = halted_reg;
        emit         = 1'b0;
        emit_code    = '0;
        emit_status  = ST_OK;
        if (accept) begin
            if (halted_reg) begin
                // drop until the end of the text
                if (s_last_byte) begin
                    halted_next = 1'b0;
                end
            end else if (pending_reg == '0) begin
                if (s_data_byte[7] == 1'b0) begin
                    emit      = 1'b1;
                    emit_code = {{(CodeWidth-ByteWidth){1'b0}}, s_data_byte};
                end else if (s_data_byte[6] == 1'b0) begin
                    emit        = 1'b1;
                    emit_status = ST_STRAY;
                end else if (!lead.valid) begin
                    emit        = 1'b1;
                    emit_status = ST_BADLEAD;
                end else if (s_last_byte) begin
                    emit        = 1'b1;
                    emit_status = ST_TRUNC;
                end else begin
                    pending_next = lead.more;
                    partial_next = {{(CodeWidth-LeadBitsWidth){1'b0}}, lead.bits};
                end
            end else if (s_data_byte[7:6] != 2'b10) begin
                emit        = 1'b1;
                emit_status = ST_BADCONT;
            end else if (pending_dec == '0) begin
                emit         = 1'b1;
                emit_code    = shifted;
                pending_next = '0;
                partial_next = '0;
            end else if (s_last_byte) begin
                emit        = 1'b1;
                emit_status = ST_TRUNC;
            end else begin
                pending_next = pending_dec;
                partial_next = shifted;
            end
            // any error clears the state and drops the rest of the text
            if (emit && emit_status != ST_OK) begin
                pending_next = '0;
                partial_next = '0;
                halted_next  = !s_last_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            partial_reg <= '0;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
            halted_reg  <= halted_next;
            if (accept && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            code_reg   <= emit_code;
            status_reg <= emit_status;
            end_reg    <= s_last_byte;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_code_point = code_reg;
    assign m_status     = status_reg;
    assign m_text_end   = end_reg;

    a_err_zero_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && status_reg != ST_OK |-> code_reg == '0)
        else $error("error word carries a nonzero code point");

    a_halt_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> pending_reg == '0 && partial_reg == '0)
        else $error("drop mode entered with sequence state left over");

    a_ascii_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !halted_reg && pending_reg == '0 && s_data_byte[7] == 1'b0
        |=> m_valid_reg && status_reg == ST_OK
            && code_reg == {{(CodeWidth-ByteWidth){1'b0}}, $past(s_data_byte)})
        else $error("single-byte character not passed through");

    a_trunc_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && status_reg == ST_TRUNC |-> end_reg)
        else $error("truncation reported away from end of text");

    a_pending_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != 3'd6 && pending_reg != 3'd7)
        else $error("continuation count out of range");

endmodule

`default_nettype wire
